@@ hdl/chs_pkg.sv @@
// package: shared types, widths and the arctangent table for the heading pipeline
package chs_pkg;

  localparam int XY_W           = 40;  // cordic x/y, holds 2^35 times gain
  localparam int ANG_W          = 32;  // binary angle, full turn is 2^32
  localparam int H_W            = 33;  // heading 0..2^32
  localparam int READ_W         = 16;
  localparam int PRESCALE_SHIFT = 20;
  localparam int ATAN_ENTRIES   = 24;
  localparam int TENTHS_W       = 12;
  localparam int PROD_W         = H_W + TENTHS_W;
  localparam int SECTOR_W       = 3;

  localparam logic [ANG_W-1:0]    HALF_TURN    = 32'h8000_0000;
  localparam logic [H_W-1:0]      FULL_TURN_H  = 33'h1_0000_0000;
  localparam logic [H_W-1:0]      HALF_TURN_H  = 33'h0_8000_0000;
  localparam logic [H_W-1:0]      QUART_TURN_H = 33'h0_4000_0000;
  localparam logic [H_W-1:0]      THREEQ_TURN_H = 33'h0_C000_0000;
  localparam logic [H_W-1:0]      SECTOR_BIAS  = 33'h0_1000_0000;
  localparam logic [TENTHS_W-1:0] TENTHS_FULL  = 12'd3600;

  localparam logic [ANG_W-1:0] ATAN_TURNS [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [ANG_W-1:0]       ang;
    logic                   ovr;    // axis case, heading fixed
    logic [H_W-1:0]         ovr_h;
  } cordic_t;

endpackage

@@ hdl/chs_prerot.sv @@
// input stage: axis cases and half-turn prerotation into cordic format
module chs_prerot (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [chs_pkg::READ_W-1:0] x_reading_i,
  input  logic signed [chs_pkg::READ_W-1:0] y_reading_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output chs_pkg::cordic_t               out_data_o
);

  logic             valid_q;
  chs_pkg::cordic_t data_q, data_d;
  logic signed [chs_pkg::XY_W-1:0] x_ext, y_ext;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    x_ext = chs_pkg::XY_W'(x_reading_i) <<< chs_pkg::PRESCALE_SHIFT;
    y_ext = chs_pkg::XY_W'(y_reading_i) <<< chs_pkg::PRESCALE_SHIFT;
    data_d = '0;
    if (x_reading_i[chs_pkg::READ_W-1]) begin
      data_d.x   = -x_ext;
      data_d.y   = -y_ext;
      data_d.ang = chs_pkg::HALF_TURN;
    end else begin
      data_d.x   = x_ext;
      data_d.y   = y_ext;
      data_d.ang = '0;
    end
    if (y_reading_i == '0) begin
      data_d.ovr   = 1'b1;
      data_d.ovr_h = x_reading_i[chs_pkg::READ_W-1] ? chs_pkg::FULL_TURN_H
                                                    : chs_pkg::HALF_TURN_H;
    end else if (x_reading_i == '0) begin
      data_d.ovr   = 1'b1;
      data_d.ovr_h = y_reading_i[chs_pkg::READ_W-1] ? chs_pkg::QUART_TURN_H
                                                    : chs_pkg::THREEQ_TURN_H;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

@@ hdl/chs_cordic.sv @@
// vectoring cordic, one registered stage per iteration
module chs_cordic #(
  parameter int STAGES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  chs_pkg::cordic_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output chs_pkg::cordic_t out_data_o
);

  chs_pkg::cordic_t src   [STAGES+1];
  logic             srcv  [STAGES+1];
  logic             rdy   [STAGES+1];
  chs_pkg::cordic_t stage_q [STAGES];
  logic             valid_q [STAGES];

  assign src[0]         = in_data_i;
  assign srcv[0]        = in_valid_i;
  assign rdy[STAGES]    = out_ready_i;
  assign in_ready_o     = rdy[0];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    chs_pkg::cordic_t cur, nxt;
    logic signed [chs_pkg::XY_W-1:0] xs, ys;

    always_comb begin
      cur = src[k];
      xs  = cur.x >>> k;  // arithmetic shift, rounds toward minus infinity
      ys  = cur.y >>> k;
      nxt = cur;
      if (!cur.y[chs_pkg::XY_W-1] && (cur.y != '0)) begin
        nxt.x   = cur.x + ys;
        nxt.y   = cur.y - xs;
        nxt.ang = cur.ang + chs_pkg::ATAN_TURNS[k];
      end else begin
        nxt.x   = cur.x - ys;
        nxt.y   = cur.y + xs;
        nxt.ang = cur.ang - chs_pkg::ATAN_TURNS[k];
      end
    end

    assign rdy[k] = !valid_q[k] || rdy[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        valid_q[k] <= srcv[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && srcv[k]) begin
        stage_q[k] <= nxt;
      end
    end

    assign src[k+1]  = stage_q[k];
    assign srcv[k+1] = valid_q[k];
  end

  assign out_valid_o = valid_q[STAGES-1];
  assign out_data_o  = stage_q[STAGES-1];

endmodule

@@ hdl/chs_post.sv @@
// output stages: degree scaling, sector code and decimal digits
module chs_post (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  chs_pkg::cordic_t                 in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [chs_pkg::TENTHS_W-1:0]     heading_tenths_o,
  output logic [1:0]                       digit_hundreds_o,
  output logic [3:0]                       digit_tens_o,
  output logic [3:0]                       digit_units_o,
  output logic [3:0]                       digit_tenths_o,
  output logic [chs_pkg::SECTOR_W-1:0]     sector_o
);

  localparam int NSTG = 3;

  logic valid_q [NSTG];
  logic rdy     [NSTG+1];

  // stage 1: heading and product
  logic [chs_pkg::H_W-1:0]      h;
  logic [chs_pkg::PROD_W-1:0]   prod;
  logic [chs_pkg::H_W-1:0]      sec_sum;
  logic [chs_pkg::TENTHS_W-1:0] t1_q;
  logic [chs_pkg::SECTOR_W-1:0] s1_q;

  // stage 2: hundreds and tens
  logic [1:0]                   hun_d;
  logic [9:0]                   r1;
  logic [3:0]                   tens_d;
  logic [6:0]                   r2_d;
  logic [chs_pkg::TENTHS_W-1:0] t2_q;
  logic [chs_pkg::SECTOR_W-1:0] s2_q;
  logic [1:0]                   hun2_q;
  logic [3:0]                   tens2_q;
  logic [6:0]                   r2_q;

  // stage 3: units and tenths
  logic [3:0]                   units_d;
  logic [3:0]                   tenths_d;
  logic [chs_pkg::TENTHS_W-1:0] t3_q;
  logic [chs_pkg::SECTOR_W-1:0] s3_q;
  logic [1:0]                   hun3_q;
  logic [3:0]                   tens3_q;
  logic [3:0]                   units3_q;
  logic [3:0]                   tenths3_q;

  logic srcv [NSTG];
  assign srcv[0] = in_valid_i;
  assign srcv[1] = valid_q[0];
  assign srcv[2] = valid_q[1];

  assign rdy[NSTG]  = out_ready_i;
  assign in_ready_o = rdy[0];

  for (genvar k = 0; k < NSTG; k++) begin : g_ctl
    assign rdy[k] = !valid_q[k] || rdy[k+1];
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        valid_q[k] <= srcv[k];
      end
    end
  end

  // adding a half turn mod 2^32 flips the top angle bit
  always_comb begin
    h = in_data_i.ovr ? in_data_i.ovr_h
                      : {1'b0, ~in_data_i.ang[chs_pkg::ANG_W-1],
                         in_data_i.ang[chs_pkg::ANG_W-2:0]};
    prod    = chs_pkg::PROD_W'(h) * chs_pkg::PROD_W'(chs_pkg::TENTHS_FULL);
    sec_sum = h + chs_pkg::SECTOR_BIAS;
  end

  // product stays below 3601 * 2^32, so its top bit is always clear
  always_ff @(posedge clk_i) begin
    if (rdy[0] && srcv[0]) begin
      t1_q <= prod[chs_pkg::ANG_W+chs_pkg::TENTHS_W-1:chs_pkg::ANG_W];
      s1_q <= sec_sum[31:29];
    end
  end

  always_comb begin
    if (t1_q >= 12'd3000) begin
      hun_d = 2'd3;
    end else if (t1_q >= 12'd2000) begin
      hun_d = 2'd2;
    end else if (t1_q >= 12'd1000) begin
      hun_d = 2'd1;
    end else begin
      hun_d = 2'd0;
    end
    r1 = 10'(t1_q - 12'(hun_d) * 12'd1000);
    tens_d = '0;
    for (int k = 1; k < 10; k++) begin
      if (r1 >= 10'(k * 100)) begin
        tens_d = 4'(k);
      end
    end
    r2_d = 7'(r1 - 10'(tens_d) * 10'd100);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1] && srcv[1]) begin
      t2_q    <= t1_q;
      s2_q    <= s1_q;
      hun2_q  <= hun_d;
      tens2_q <= tens_d;
      r2_q    <= r2_d;
    end
  end

  always_comb begin
    units_d = '0;
    for (int k = 1; k < 10; k++) begin
      if (r2_q >= 7'(k * 10)) begin
        units_d = 4'(k);
      end
    end
    tenths_d = 4'(r2_q - 7'(units_d) * 7'd10);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2] && srcv[2]) begin
      t3_q      <= t2_q;
      s3_q      <= s2_q;
      hun3_q    <= hun2_q;
      tens3_q   <= tens2_q;
      units3_q  <= units_d;
      tenths3_q <= tenths_d;
    end
  end

  assign out_valid_o      = valid_q[NSTG-1];
  assign heading_tenths_o = t3_q;
  assign digit_hundreds_o = hun3_q;
  assign digit_tens_o     = tens3_q;
  assign digit_units_o    = units3_q;
  assign digit_tenths_o   = tenths3_q;
  assign sector_o         = s3_q;

endmodule

@@ hdl/compass_heading_sector.sv @@
// compass heading top level, one register stage per cordic iteration
// throughput one item per cycle while the output is not stalled
// every stage holds its item under backpressure and takes a new one when freed
// reset (rst_ni low, asynchronous) clears all valid bits; data registers are not reset
//
// flow: prerotation/axis detect -> cordic iterations -> scale, sector, digits
module compass_heading_sector #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic signed [15:0] x_reading_i,
  input  logic signed [15:0] y_reading_i,
  // result item channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] heading_tenths_o,
  output logic [1:0]  digit_hundreds_o,
  output logic [3:0]  digit_tens_o,
  output logic [3:0]  digit_units_o,
  output logic [3:0]  digit_tenths_o,
  output logic [2:0]  sector_o
);

  // iterations past the arctangent table are not done
  localparam int STAGES = (CORDIC_STEPS < chs_pkg::ATAN_ENTRIES) ? CORDIC_STEPS
                                                                 : chs_pkg::ATAN_ENTRIES;

  logic             pre_valid, pre_ready;
  chs_pkg::cordic_t pre_data;
  logic             cor_valid, cor_ready;
  chs_pkg::cordic_t cor_data;

  // axis cases get a fixed heading, left half plane turned by a half turn
  chs_prerot u_prerot (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .x_reading_i (x_reading_i),
    .y_reading_i (y_reading_i),
    .out_valid_o (pre_valid),
    .out_ready_i (pre_ready),
    .out_data_o  (pre_data)
  );

  // drives y toward zero, accumulating the binary angle
  chs_cordic #(
    .STAGES (STAGES)
  ) u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pre_valid),
    .in_ready_o  (pre_ready),
    .in_data_i   (pre_data),
    .out_valid_o (cor_valid),
    .out_ready_i (cor_ready),
    .out_data_o  (cor_data)
  );

  // heading plus half turn, scaled to tenths, sector and decimal split
  chs_post u_post (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (cor_valid),
    .in_ready_o       (cor_ready),
    .in_data_i        (cor_data),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .heading_tenths_o (heading_tenths_o),
    .digit_hundreds_o (digit_hundreds_o),
    .digit_tens_o     (digit_tens_o),
    .digit_units_o    (digit_units_o),
    .digit_tenths_o   (digit_tenths_o),
    .sector_o         (sector_o)
  );

endmodule
